[rtl/wsfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package wsfd_pkg;

  // Parser phase codes. The unused codes behave as the first header byte.
  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  // Header field constants.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // One result transaction as it leaves the parser.
  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] frame_opcode;
    logic       final_fragment;
    logic       last_of_frame;
    logic       empty_frame;
  } result_t;

endpackage

`default_nettype wire

[rtl/wsfd_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module wsfd_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       advance_i,
  output logic            byte_valid_o,
  output logic [7:0]      byte_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;

  // The register holds its byte only while the parser cannot move it on.
  assign in_stall_o = vld_q && !advance_i;
  assign vld_d      = in_stall_o ? vld_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload register, loaded on each accepted transaction.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

  assign byte_valid_o = vld_q;
  assign byte_o       = byte_q;

endmodule

`default_nettype wire

[rtl/wsfd_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

module wsfd_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  output logic                  res_valid_o,
  output wsfd_pkg::result_t     res_o
);

  logic [2:0]  phase_q, phase_d;
  logic        fin_q, fin_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        masked_q, masked_d;
  logic [63:0] remain_q, remain_d;
  logic [3:0]  ext_cnt_q, ext_cnt_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  key_pos_q, key_pos_d;

  logic [6:0]  len7;
  logic [3:0]  cnt_dec;
  logic [7:0]  key_byte;
  logic        res_vld;
  logic        res_last;
  logic        res_empty;
  logic [7:0]  res_data;

  assign len7    = byte_i[6:0];
  assign cnt_dec = ext_cnt_q - 4'd1;

  // Key byte for the current payload position; key byte 0 sits in the top bits.
  always_comb begin
    case (key_pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Next state and result for one stream byte.
  always_comb begin
    phase_d   = phase_q;
    fin_d     = fin_q;
    opcode_d  = opcode_q;
    masked_d  = masked_q;
    remain_d  = remain_q;
    ext_cnt_d = ext_cnt_q;
    key_d     = key_q;
    key_pos_d = key_pos_q;
    res_vld   = 1'b0;
    res_last  = 1'b0;
    res_empty = 1'b0;
    res_data  = 8'd0;
    case (phase_q)
      wsfd_pkg::PH_HDR1: begin
        masked_d = byte_i[7];
        remain_d = '0;
        if (len7 == wsfd_pkg::LEN_EXT16) begin
          ext_cnt_d = wsfd_pkg::EXT16_BYTES;
          phase_d   = wsfd_pkg::PH_EXTLEN;
        end else if (len7 == wsfd_pkg::LEN_EXT64) begin
          ext_cnt_d = wsfd_pkg::EXT64_BYTES;
          phase_d   = wsfd_pkg::PH_EXTLEN;
        end else begin
          remain_d  = {57'd0, len7};
          key_pos_d = 2'd0;
          if (byte_i[7]) begin
            ext_cnt_d = wsfd_pkg::KEY_BYTES;
            key_d     = '0;
            phase_d   = wsfd_pkg::PH_KEY;
          end else if (len7 == 7'd0) begin
            res_vld   = 1'b1;
            res_last  = 1'b1;
            res_empty = 1'b1;
            phase_d   = wsfd_pkg::PH_HDR0;
          end else begin
            phase_d = wsfd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfd_pkg::PH_EXTLEN: begin
        remain_d  = {remain_q[55:0], byte_i};
        ext_cnt_d = cnt_dec;
        if (cnt_dec == 4'd0) begin
          key_pos_d = 2'd0;
          if (masked_q) begin
            ext_cnt_d = wsfd_pkg::KEY_BYTES;
            key_d     = '0;
            phase_d   = wsfd_pkg::PH_KEY;
          end else if ({remain_q[55:0], byte_i} == 64'd0) begin
            res_vld   = 1'b1;
            res_last  = 1'b1;
            res_empty = 1'b1;
            phase_d   = wsfd_pkg::PH_HDR0;
          end else begin
            phase_d = wsfd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfd_pkg::PH_KEY: begin
        key_d     = {key_q[23:0], byte_i};
        ext_cnt_d = cnt_dec;
        if (cnt_dec == 4'd0) begin
          key_pos_d = 2'd0;
          if (remain_q == 64'd0) begin
            res_vld   = 1'b1;
            res_last  = 1'b1;
            res_empty = 1'b1;
            phase_d   = wsfd_pkg::PH_HDR0;
          end else begin
            phase_d = wsfd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        key_pos_d = key_pos_q + 2'd1;
        remain_d  = remain_q - 64'd1;
        res_vld   = 1'b1;
        res_data  = masked_q ? (byte_i ^ key_byte) : byte_i;
        if (remain_q == 64'd1) begin
          res_last = 1'b1;
          phase_d  = wsfd_pkg::PH_HDR0;
        end
      end
      default: begin
        fin_d    = byte_i[7];
        opcode_d = byte_i[3:0];
        phase_d  = wsfd_pkg::PH_HDR1;
      end
    endcase
  end

  // Parser state advances once per byte handed to the output side.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= wsfd_pkg::PH_HDR0;
      fin_q     <= 1'b0;
      opcode_q  <= 4'd0;
      masked_q  <= 1'b0;
      remain_q  <= '0;
      ext_cnt_q <= 4'd0;
      key_q     <= '0;
      key_pos_q <= 2'd0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      fin_q     <= fin_d;
      opcode_q  <= opcode_d;
      masked_q  <= masked_d;
      remain_q  <= remain_d;
      ext_cnt_q <= ext_cnt_d;
      key_q     <= key_d;
      key_pos_q <= key_pos_d;
    end
  end

  // Opcode and fin come from the current frame, as held before this byte.
  assign res_valid_o          = step_i && res_vld;
  assign res_o.data_byte      = res_data;
  assign res_o.frame_opcode   = opcode_q;
  assign res_o.final_fragment = fin_q;
  assign res_o.last_of_frame  = res_last;
  assign res_o.empty_frame    = res_empty;

endmodule

`default_nettype wire

[rtl/wsfd_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none

module wsfd_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              res_valid_i,
  input  wire wsfd_pkg::result_t res_i,
  output logic                   advance_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output wsfd_pkg::result_t      res_o
);

  logic              vld_q, vld_d;
  wsfd_pkg::result_t res_q;

  // The register can take a new result when empty or being drained this cycle.
  assign advance_o = !vld_q || !out_stall_i;
  assign vld_d     = advance_o ? res_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

[rtl/websocket_frame_deframer_unit.sv]
// Path: an accepted byte is held in the input register, then its result in the
//   result register, which drives out_valid_o. The parser steps once per byte.
// Throughput: one byte per cycle unless out_stall_i holds the result register.
// Reset: rst_ni is asynchronous and active low; it empties both registers and
//   puts the parser at the first header byte of a frame.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      data_byte_o,
  output logic [3:0]      frame_opcode_o,
  output logic            final_fragment_o,
  output logic            last_of_frame_o,
  output logic            empty_frame_o
);

  logic              advance;
  logic              byte_valid;
  logic [7:0]        byte_val;
  logic              step;
  logic              res_valid;
  wsfd_pkg::result_t res;
  wsfd_pkg::result_t out_res;

  wsfd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .advance_i    (advance),
    .byte_valid_o (byte_valid),
    .byte_o       (byte_val)
  );

  // A byte is consumed when present and the result register can take its result.
  assign step = byte_valid && advance;

  wsfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (byte_val),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign data_byte_o      = out_res.data_byte;
  assign frame_opcode_o   = out_res.frame_opcode;
  assign final_fragment_o = out_res.final_fragment;
  assign last_of_frame_o  = out_res.last_of_frame;
  assign empty_frame_o    = out_res.empty_frame;

endmodule

`default_nettype wire

[rtl/wsfd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module wsfd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] in_byte_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] data_byte_o,
  input wire logic [3:0] frame_opcode_o,
  input wire logic       final_fragment_o,
  input wire logic       last_of_frame_o,
  input wire logic       empty_frame_o
);

  // A stalled input transaction stays valid and keeps its byte.
  a_in_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_byte_i))
    else $error("input transaction changed while stalled");

  // A stalled result transaction stays valid.
  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  // A stalled result transaction keeps its payload.
  a_out_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(data_byte_o) && $stable(frame_opcode_o)
      && $stable(final_fragment_o) && $stable(last_of_frame_o)
      && $stable(empty_frame_o))
    else $error("result payload changed while stalled");

  // The input side backs up only behind a stalled, full result register.
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // An empty frame result carries a zero byte and closes the frame.
  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_frame_o |-> last_of_frame_o && data_byte_o == 8'd0)
    else $error("empty frame result malformed");

endmodule

bind websocket_frame_deframer_unit wsfd_checker u_wsfd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .in_byte_i        (in_byte_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .data_byte_o      (data_byte_o),
  .frame_opcode_o   (frame_opcode_o),
  .final_fragment_o (final_fragment_o),
  .last_of_frame_o  (last_of_frame_o),
  .empty_frame_o    (empty_frame_o)
);

`default_nettype wire
